// File: rtl/rfhf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfhf_pkg
// Shared types and constants of the receive frame header filter.
// ----------------------------------------------------------------------------
package rfhf_pkg;

  localparam int unsigned MAX_FRAME_BYTES_DEF = 127;

  localparam int unsigned CFG_INDEX_W = 2;
  localparam int unsigned POS_W = 9;

  localparam logic [CFG_INDEX_W-1:0] CFG_DEVICE_MODE = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_ACK_REQUEST = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_ACCEPT_ALL  = 2'd2;

  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  localparam logic [7:0] FC_ACK    = 8'h61;
  localparam logic [7:0] FC_NO_ACK = 8'h41;
  localparam logic [7:0] ADDR_MODE = 8'h88;
  localparam logic [7:0] SEQ_RESET = 8'hFF;
  localparam logic [15:0] BCAST_ADDR = 16'hFFFF;

  localparam logic [7:0] FCS_BYTES = 8'd2;
  localparam logic [7:0] MIN_DEVICE_LEN = 8'd11;
  localparam logic [7:0] DEVICE_OVERHEAD = 8'd11;

  localparam logic [POS_W-1:0] POS_FC      = 9'd0;
  localparam logic [POS_W-1:0] POS_ADDR    = 9'd1;
  localparam logic [POS_W-1:0] POS_SEQ     = 9'd2;
  localparam logic [POS_W-1:0] POS_PAN_LO  = 9'd3;
  localparam logic [POS_W-1:0] POS_PAN_HI  = 9'd4;
  localparam logic [POS_W-1:0] POS_DST_LO  = 9'd5;
  localparam logic [POS_W-1:0] POS_DST_HI  = 9'd6;
  localparam logic [POS_W-1:0] POS_SRC_LO  = 9'd7;
  localparam logic [POS_W-1:0] POS_SRC_HI  = 9'd8;

  typedef struct packed {
    logic device_mode;
    logic ack_request;
    logic accept_all;
  } rfhf_cfg_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  data_byte;
    logic [6:0]  payload_length;
    logic [7:0]  frame_seq;
    logic [15:0] pan_id;
    logic [15:0] dest_id;
    logic [15:0] source_id;
    logic [7:0]  link_quality;
    logic [7:0]  energy_out;
    logic        crc_ok;
    logic        last;
  } rfhf_result_t;

endpackage

// File: rtl/rfhf_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfhf_parser
// Per-byte frame tracking, header check and capture, duplicate filtering.
// ----------------------------------------------------------------------------
module rfhf_parser #(
  parameter int unsigned MAX_FRAME_BYTES = rfhf_pkg::MAX_FRAME_BYTES_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  rfhf_pkg::rfhf_cfg_t   cfg,
  input  logic                  in_accept,
  input  logic [7:0]            rx_byte,
  input  logic                  frame_start,
  input  logic [7:0]            energy_level,
  input  logic                  crc_valid,
  output logic                  res_valid,
  output rfhf_pkg::rfhf_result_t res
);
  import rfhf_pkg::*;

  localparam logic [7:0] MaxLen = 8'(MAX_FRAME_BYTES);

  typedef struct packed {
    logic [7:0]       last_seq;
    logic [7:0]       frame_len;
    logic [POS_W-1:0] byte_pos;
    logic             in_frame;
    logic             frame_accepted;
    logic             frame_raw;
    logic [7:0]       header_seq;
    logic [15:0]      header_pan;
    logic [15:0]      header_dst;
    logic [15:0]      header_src;
    logic [7:0]       saved_lqi;
    logic [7:0]       saved_energy;
  } rfhf_state_t;

  rfhf_state_t st;
  rfhf_state_t st_next;

  logic [POS_W-1:0] len_ext;
  logic             in_payload;
  logic [7:0]       plen_raw;

  assign len_ext = {1'b0, st.frame_len};
  assign in_payload = (st.byte_pos + POS_W'(FCS_BYTES)) < len_ext;
  assign plen_raw = st.frame_len - (st.frame_raw ? FCS_BYTES : DEVICE_OVERHEAD);

  always_comb begin
    st_next = st;
    res_valid = 1'b0;
    res = '0;
    if (in_accept) begin
      if (frame_start) begin
        st_next.frame_len = rx_byte;
        st_next.saved_energy = energy_level;
        st_next.byte_pos = '0;
        st_next.frame_raw = !cfg.device_mode;
        st_next.frame_accepted = 1'b0;
        st_next.saved_lqi = '0;
        st_next.in_frame = (rx_byte <= MaxLen) &&
                           (cfg.device_mode ? (rx_byte >= MIN_DEVICE_LEN) :
                                              (rx_byte >= FCS_BYTES));
      end else if (st.in_frame) begin
        st_next.byte_pos = st.byte_pos + POS_W'(1);
        if (st.byte_pos == len_ext + POS_W'(1)) begin
          st_next.in_frame = 1'b0;
          if (st.frame_raw || st.frame_accepted) begin
            res_valid = 1'b1;
            res.kind = KIND_SUMMARY;
            res.payload_length = plen_raw[7] ? 7'h7F : plen_raw[6:0];
            res.crc_ok = crc_valid;
            res.last = 1'b1;
            if (!st.frame_raw) begin
              res.frame_seq = st.header_seq;
              res.pan_id = st.header_pan;
              res.dest_id = st.header_dst;
              res.source_id = st.header_src;
              res.link_quality = st.saved_lqi;
              res.energy_out = st.saved_energy;
            end
          end
        end else if (st.frame_raw) begin
          if (in_payload) begin
            res_valid = 1'b1;
            res.kind = KIND_PAYLOAD;
            res.data_byte = rx_byte;
          end
        end else begin
          case (st.byte_pos)
            POS_FC: begin
              st_next.frame_accepted = cfg.ack_request ? (rx_byte == FC_ACK) :
                                                         (rx_byte == FC_NO_ACK);
            end
            POS_ADDR: begin
              if (rx_byte != ADDR_MODE) begin
                st_next.frame_accepted = 1'b0;
              end
            end
            POS_SEQ: st_next.header_seq = rx_byte;
            POS_PAN_LO: st_next.header_pan[7:0] = rx_byte;
            POS_PAN_HI: st_next.header_pan[15:8] = rx_byte;
            POS_DST_LO: st_next.header_dst[7:0] = rx_byte;
            POS_DST_HI: st_next.header_dst[15:8] = rx_byte;
            POS_SRC_LO: st_next.header_src[7:0] = rx_byte;
            POS_SRC_HI: begin
              st_next.header_src[15:8] = rx_byte;
              if (st.frame_accepted && !cfg.accept_all && st.header_dst != BCAST_ADDR) begin
                if (st.last_seq != st.header_seq) begin
                  st_next.last_seq = st.header_seq;
                end else begin
                  st_next.frame_accepted = 1'b0;
                end
              end
            end
            default: begin
              if (in_payload) begin
                if (st.frame_accepted) begin
                  res_valid = 1'b1;
                  res.kind = KIND_PAYLOAD;
                  res.data_byte = rx_byte;
                end
              end else if (st.byte_pos == len_ext) begin
                st_next.saved_lqi = rx_byte;
              end
            end
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '{last_seq: SEQ_RESET, default: '0};
    end else begin
      st <= st_next;
    end
  end

endmodule

// File: rtl/rfhf_out_buf.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfhf_out_buf
// Result register that holds one request until the downstream side takes it.
// ----------------------------------------------------------------------------
module rfhf_out_buf (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_accept,
  input  logic                   res_valid,
  input  rfhf_pkg::rfhf_result_t res,
  input  logic                   out_stall,
  output logic                   out_valid,
  output logic                   busy,
  output rfhf_pkg::rfhf_result_t out_res
);
  import rfhf_pkg::*;

  assign busy = out_valid && out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_accept) begin
      out_valid <= res_valid;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept && res_valid) begin
      out_res <= res;
    end
  end

endmodule

// File: rtl/rx_frame_header_filter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rx_frame_header_filter
// Receive filter for short-address data frames: checks and captures the
// header and drops duplicates in device mode, streams payload bytes and a frame summary.
// ----------------------------------------------------------------------------
//  Channel   Handshake            Contents
//  in        in_valid / in_stall  rx_byte, frame_start, energy_level, crc_valid
//  out       out_valid / out_stall  one payload byte or one frame summary
//  cfg       cfg_valid / cfg_ready  cfg_index, cfg_data (always ready)
//
//  Each request is handled combinationally; its result appears in the output
//  register in the cycle after acceptance, and one request can enter every
//  cycle while in_stall is low. in_stall is high only while the output
//  register holds a result that is stalled. Reset is synchronous and restores
//  the register defaults and the last sequence number of 0xFF.
// ----------------------------------------------------------------------------
module rx_frame_header_filter #(
  parameter int unsigned MAX_FRAME_BYTES = rfhf_pkg::MAX_FRAME_BYTES_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [7:0]                       rx_byte,
  input  logic                             frame_start,
  input  logic [7:0]                       energy_level,
  input  logic                             crc_valid,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             kind,
  output logic [7:0]                       data_byte,
  output logic [6:0]                       payload_length,
  output logic [7:0]                       frame_seq,
  output logic [15:0]                      pan_id,
  output logic [15:0]                      dest_id,
  output logic [15:0]                      source_id,
  output logic [7:0]                       link_quality,
  output logic [7:0]                       energy_out,
  output logic                             crc_ok,
  output logic                             last,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [rfhf_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic                             cfg_data
);
  import rfhf_pkg::*;

  rfhf_cfg_t    cfg;
  logic         in_accept;
  logic         res_valid;
  logic         busy;
  rfhf_result_t res;
  rfhf_result_t out_res;

  assign cfg_ready = 1'b1;
  assign in_stall = busy;
  assign in_accept = in_valid && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.device_mode <= 1'b1;
      cfg.ack_request <= 1'b0;
      cfg.accept_all <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_DEVICE_MODE: cfg.device_mode <= cfg_data;
        CFG_ACK_REQUEST: cfg.ack_request <= cfg_data;
        CFG_ACCEPT_ALL:  cfg.accept_all <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  rfhf_parser #(
    .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
  ) u_parser (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .in_accept   (in_accept),
    .rx_byte     (rx_byte),
    .frame_start (frame_start),
    .energy_level(energy_level),
    .crc_valid   (crc_valid),
    .res_valid   (res_valid),
    .res         (res)
  );

  rfhf_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .in_accept (in_accept),
    .res_valid (res_valid),
    .res       (res),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .busy      (busy),
    .out_res   (out_res)
  );

  assign kind = out_res.kind;
  assign data_byte = out_res.data_byte;
  assign payload_length = out_res.payload_length;
  assign frame_seq = out_res.frame_seq;
  assign pan_id = out_res.pan_id;
  assign dest_id = out_res.dest_id;
  assign source_id = out_res.source_id;
  assign link_quality = out_res.link_quality;
  assign energy_out = out_res.energy_out;
  assign crc_ok = out_res.crc_ok;
  assign last = out_res.last;

endmodule

// File: rtl/rfhf_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfhf_checker
// Port-level checks of the receive frame header filter.
// ----------------------------------------------------------------------------
module rfhf_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic        kind,
  input logic [7:0]  data_byte,
  input logic [6:0]  payload_length,
  input logic [7:0]  frame_seq,
  input logic [15:0] pan_id,
  input logic        last
);
  import rfhf_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(data_byte) && $stable(kind))
    else $error("Stalled result changed.");

  a_summary: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == KIND_SUMMARY |-> last && data_byte == 8'd0)
    else $error("Summary without last or with a data byte.");

  a_payload: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == KIND_PAYLOAD |->
      !last && payload_length == 7'd0 && frame_seq == 8'd0 && pan_id == 16'd0)
    else $error("Payload result carries summary fields.");

  a_no_stall_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> !in_stall)
    else $error("Input stalled while the output register is empty.");

endmodule

bind rx_frame_header_filter rfhf_checker u_rfhf_checker (
  .clk           (clk),
  .rst           (rst),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .kind          (kind),
  .data_byte     (data_byte),
  .payload_length(payload_length),
  .frame_seq     (frame_seq),
  .pan_id        (pan_id),
  .last          (last)
);
